>>> hw/rtl/htbd_pkg.sv
package htbd_pkg;

  // Tree geometry
  localparam int unsigned MAX_NODES = 256;
  localparam int unsigned NODE_W    = $clog2(MAX_NODES);
  localparam int unsigned TOTAL_W   = NODE_W + 1;

  // Child encoding: a negative child v is the leaf for symbol -(v+1)
  localparam logic [14:0]        END_SYMBOL = 15'd256;
  localparam logic signed [15:0] END_LEAF   = -16'sd257;

  // Input operations
  localparam logic [1:0] OP_HEADER = 2'd0;
  localparam logic [1:0] OP_ENTRY  = 2'd1;
  localparam logic [1:0] OP_BYTE   = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Microprogram step addresses
  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_HDR   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_ENT   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_BYTE  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_WALK  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_FLUSH = 3'd5;

  typedef struct packed {
    logic [1:0]         op;
    logic [15:0]        node_count;
    logic [7:0]         node_index;
    logic signed [15:0] left_child;
    logic signed [15:0] right_child;
    logic [7:0]         data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic [1:0] kind;
    logic       last;
  } out_item_t;

  // Jump condition of a control word
  typedef enum logic [1:0] {
    COND_ALWAYS  = 2'd0,
    COND_OP      = 2'd1,
    COND_STOPPED = 2'd2,
    COND_LAST    = 2'd3
  } cond_e;

  typedef struct packed {
    logic              ready;
    logic              hdr;
    logic              ent;
    logic              start;
    logic              walk;
    logic              flush;
    cond_e             cond;
    logic [STEP_W-1:0] tgt_t;
    logic [STEP_W-1:0] tgt_f;
  } ucode_t;

  // Control store: one control word per step
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] pc);
    ucode_t w;
    w = '{ready: 1'b0, hdr: 1'b0, ent: 1'b0, start: 1'b0, walk: 1'b0, flush: 1'b0,
          cond: COND_ALWAYS, tgt_t: STEP_IDLE, tgt_f: STEP_IDLE};
    case (pc)
      STEP_IDLE: begin
        w.ready = 1'b1;
        w.cond  = COND_OP;
      end
      STEP_HDR: begin
        w.hdr   = 1'b1;
        w.tgt_t = STEP_FLUSH;
      end
      STEP_ENT: begin
        w.ent = 1'b1;
      end
      STEP_BYTE: begin
        w.start = 1'b1;
        w.cond  = COND_STOPPED;
        w.tgt_t = STEP_IDLE;
        w.tgt_f = STEP_WALK;
      end
      STEP_WALK: begin
        w.walk  = 1'b1;
        w.cond  = COND_LAST;
        w.tgt_t = STEP_FLUSH;
        w.tgt_f = STEP_WALK;
      end
      STEP_FLUSH: begin
        w.flush = 1'b1;
      end
      default: begin
        w.tgt_t = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/huffman_tree_bit_decoder.sv
// Steps per transaction, from acceptance to the next acceptance: tree entry idle and entry,
// header idle, header and flush, compressed byte idle and setup once the stream has stopped,
// else idle, one setup step, one step per bit walked, one flush step, plus any output stall.
// Throughput: one tree bit per cycle unless the output stalls, set by the single registered
// read port of the tree memory that feeds the walk; an item is accepted only in the idle step.
// Reset clears sequencer, node count, walk position and end/error flags; tree memory is kept.
module huffman_tree_bit_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  htbd_pkg::in_item_t   in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output htbd_pkg::out_item_t  out_o
);

  // Sequencer
  logic [htbd_pkg::STEP_W-1:0] pc_q, pc_d;
  htbd_pkg::ucode_t            uw;

  // Datapath state
  htbd_pkg::in_item_t               item_q;
  logic [htbd_pkg::TOTAL_W-1:0]     total_q, total_d;
  logic [htbd_pkg::NODE_W-1:0]      walk_q, walk_d;
  logic                             done_q, done_d;
  logic                             err_q, err_d;
  logic [2:0]                       cnt_q, cnt_d;
  logic                             pend_valid_q, pend_valid_d;
  logic [7:0]                       pend_sym_q, pend_sym_d;
  logic [1:0]                       pend_kind_q, pend_kind_d;
  logic                             out_valid_q, out_valid_d;
  htbd_pkg::out_item_t              out_q, out_d;

  // Tree memory: {right, left} per node
  logic [31:0]                      tree_mem [htbd_pkg::MAX_NODES];
  logic [31:0]                      rd_q;
  logic                             mem_we;
  logic [htbd_pkg::NODE_W-1:0]      mem_waddr;
  logic [31:0]                      mem_wdata;

  // Walk evaluation
  logic               accept;
  logic               out_free;
  logic               bit_w;
  logic [15:0]        child;
  logic [15:0]        sym_full;
  logic               is_leaf;
  logic               res_valid;
  logic [7:0]         res_sym;
  logic [1:0]         res_kind;
  logic               res_term;
  logic               stop;
  logic               stall;
  logic               hdr_bad;

  assign uw         = htbd_pkg::ucode_rom(pc_q);
  assign in_ready_o = uw.ready;
  assign accept     = in_valid_i & uw.ready;
  assign out_free   = ~out_valid_q | out_ready_i;

  // Decode one tree bit from the node read in the previous cycle
  always_comb begin
    bit_w    = item_q.data_byte[cnt_q];
    child    = bit_w ? rd_q[31:16] : rd_q[15:0];
    is_leaf  = child[15];
    sym_full = ~child;
    res_valid = 1'b0;
    res_sym   = '0;
    res_kind  = htbd_pkg::KIND_DATA;
    res_term  = 1'b0;
    if (!is_leaf) begin
      if (child[14:0] >= {{(15 - htbd_pkg::TOTAL_W){1'b0}}, total_q}) begin
        res_valid = 1'b1;
        res_kind  = htbd_pkg::KIND_ERROR;
        res_term  = 1'b1;
      end
    end else if (sym_full[14:0] > htbd_pkg::END_SYMBOL) begin
      res_valid = 1'b1;
      res_kind  = htbd_pkg::KIND_ERROR;
      res_term  = 1'b1;
    end else if (sym_full[14:0] == htbd_pkg::END_SYMBOL) begin
      res_valid = 1'b1;
      res_kind  = htbd_pkg::KIND_END;
      res_term  = 1'b1;
    end else begin
      res_valid = 1'b1;
      res_sym   = sym_full[7:0];
    end
    stop = res_term | (cnt_q == 3'd7);
  end

  // Hold the step while a result cannot move on to the output register
  always_comb begin
    stall = 1'b0;
    if (uw.walk && res_valid && pend_valid_q && !out_free) begin
      stall = 1'b1;
    end
    if (uw.flush && pend_valid_q && !out_free) begin
      stall = 1'b1;
    end
  end

  assign hdr_bad = (item_q.node_count >= 16'(htbd_pkg::MAX_NODES));

  // Next step address
  always_comb begin
    pc_d = pc_q;
    if (!stall) begin
      case (uw.cond)
        htbd_pkg::COND_ALWAYS: pc_d = uw.tgt_t;
        htbd_pkg::COND_OP: begin
          if (in_valid_i) begin
            case (in_i.op)
              htbd_pkg::OP_HEADER: pc_d = htbd_pkg::STEP_HDR;
              htbd_pkg::OP_ENTRY:  pc_d = htbd_pkg::STEP_ENT;
              htbd_pkg::OP_BYTE:   pc_d = htbd_pkg::STEP_BYTE;
              default:             pc_d = uw.tgt_f;
            endcase
          end else begin
            pc_d = uw.tgt_f;
          end
        end
        htbd_pkg::COND_STOPPED: pc_d = (done_q | err_q) ? uw.tgt_t : uw.tgt_f;
        htbd_pkg::COND_LAST:    pc_d = stop ? uw.tgt_t : uw.tgt_f;
        default:                pc_d = htbd_pkg::STEP_IDLE;
      endcase
    end
  end

  // Datapath actions selected by the control word
  always_comb begin
    total_d      = total_q;
    walk_d       = walk_q;
    done_d       = done_q;
    err_d        = err_q;
    cnt_d        = cnt_q;
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    pend_kind_d  = pend_kind_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_d        = out_q;
    mem_we       = 1'b0;
    mem_waddr    = item_q.node_index;
    mem_wdata    = {item_q.right_child, item_q.left_child};

    if (uw.hdr) begin
      walk_d    = '0;
      done_d    = 1'b0;
      err_d     = hdr_bad;
      total_d   = hdr_bad ? '0 : item_q.node_count[htbd_pkg::TOTAL_W-1:0];
      mem_we    = 1'b1;
      mem_waddr = '0;
      mem_wdata = {htbd_pkg::END_LEAF, htbd_pkg::END_LEAF};
      if (hdr_bad) begin
        pend_valid_d = 1'b1;
        pend_sym_d   = '0;
        pend_kind_d  = htbd_pkg::KIND_ERROR;
      end
    end

    if (uw.ent) begin
      mem_we = 1'b1;
    end

    if (uw.start) begin
      cnt_d = '0;
    end

    if (uw.walk && !stall) begin
      cnt_d = cnt_q + 3'd1;
      if (!is_leaf) begin
        if (!res_term) begin
          walk_d = child[htbd_pkg::NODE_W-1:0];
        end
      end else begin
        walk_d = '0;
      end
      if (res_kind == htbd_pkg::KIND_ERROR && res_valid) begin
        err_d = 1'b1;
      end
      if (res_kind == htbd_pkg::KIND_END && res_valid) begin
        done_d = 1'b1;
      end
      if (res_valid) begin
        // Push the older pending result out; it cannot be the last one
        if (pend_valid_q) begin
          out_valid_d = 1'b1;
          out_d       = '{symbol: pend_sym_q, kind: pend_kind_q, last: 1'b0};
        end
        pend_valid_d = 1'b1;
        pend_sym_d   = res_sym;
        pend_kind_d  = res_kind;
      end
    end

    // Drain the final result of the transaction with its last flag
    if (uw.flush && !stall && pend_valid_q) begin
      out_valid_d  = 1'b1;
      out_d        = '{symbol: pend_sym_q, kind: pend_kind_q, last: 1'b1};
      pend_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q         <= htbd_pkg::STEP_IDLE;
      total_q      <= '0;
      walk_q       <= '0;
      done_q       <= 1'b0;
      err_q        <= 1'b0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pc_q         <= pc_d;
      total_q      <= total_d;
      walk_q       <= walk_d;
      done_q       <= done_d;
      err_q        <= err_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_i;
    end
    pend_sym_q  <= pend_sym_d;
    pend_kind_q <= pend_kind_d;
    out_q       <= out_d;
  end

  // Tree memory: one write port, one registered read port addressed by the next node
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tree_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= tree_mem[walk_d];
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Nothing waits in the pending slot while the sequencer is idle
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (pc_q != htbd_pkg::STEP_IDLE))
    else $error("pending result left behind in idle step");

  // A walk never runs once the stream has ended or failed
  a_walk_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == htbd_pkg::STEP_WALK) |-> !(done_q || err_q))
    else $error("walk step active after end or error");

  // End and error results always close their transaction
  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_o.kind != htbd_pkg::KIND_DATA)) |-> (out_o.last && out_o.symbol == '0))
    else $error("end or error result without last flag or with a symbol");

  // A walk step that is not stalled moves the bit counter on by one
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == htbd_pkg::STEP_WALK && !stall) |=> (cnt_q == $past(cnt_q) + 3'd1))
    else $error("bit counter did not advance");

endmodule

>>> tb/huffman_tree_bit_decoder_test.sv
module huffman_tree_bit_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         HOLD_CYCLES = 400;
  localparam int         CYCLE_LIMIT = 600000;
  localparam int         RANDOM_ITEMS = 100;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  htbd_pkg::in_item_t  in_i;
  logic                out_valid_o;
  logic                out_ready_i;
  htbd_pkg::out_item_t out_o;

  huffman_tree_bit_decoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  // Decoder shadow state
  logic signed [15:0]  tree_left  [htbd_pkg::MAX_NODES];
  logic signed [15:0]  tree_right [htbd_pkg::MAX_NODES];
  bit                  tree_written [htbd_pkg::MAX_NODES];
  int                  node_total;
  int                  walk_node;
  bit                  stream_done;
  bit                  stream_error;
  htbd_pkg::out_item_t expected_symbols[$];

  // Tree under construction for the next load
  logic signed [15:0] plan_left  [htbd_pkg::MAX_NODES];
  logic signed [15:0] plan_right [htbd_pkg::MAX_NODES];

  int        fail_count = 0;
  int        cycle_count = 0;
  int        items_done = 0;
  int        tx_calm_left = 0;
  bit        tx_gaps = 1'b1;
  bit        idle_off = 1'b0;
  int        hold_req = 0;
  int        hold_ack = 0;
  int        hold_left = 0;
  int        rx_stall_left = 0;
  int        rx_calm_left = 0;
  htbd_pkg::out_item_t got_symbol;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Walk one item through the shadow tree; queue its results, report whether it did anything
  function automatic bit decode_item(htbd_pkg::in_item_t item);
    htbd_pkg::out_item_t found[$];
    htbd_pkg::out_item_t res;
    logic signed [15:0]  child;
    int                  sym;
    int                  b;
    int                  i;
    bit                  stopped;
    bit                  effective;
    effective = 1'b1;
    res.symbol = 8'd0;
    res.last   = 1'b0;
    case (item.op)
      htbd_pkg::OP_HEADER: begin
        walk_node    = 0;
        stream_done  = 1'b0;
        stream_error = 1'b0;
        tree_left[0]    = htbd_pkg::END_LEAF;
        tree_right[0]   = htbd_pkg::END_LEAF;
        tree_written[0] = 1'b1;
        if (int'(item.node_count) >= int'(htbd_pkg::MAX_NODES)) begin
          node_total   = 0;
          stream_error = 1'b1;
          res.kind     = htbd_pkg::KIND_ERROR;
          found.push_back(res);
        end else begin
          node_total = int'(item.node_count);
        end
      end
      htbd_pkg::OP_ENTRY: begin
        tree_left[item.node_index]    = item.left_child;
        tree_right[item.node_index]   = item.right_child;
        tree_written[item.node_index] = 1'b1;
      end
      htbd_pkg::OP_BYTE: begin
        stopped   = stream_done || stream_error;
        effective = !stopped;
        for (b = 0; b < 8 && !stopped; b++) begin
          child = item.data_byte[b] ? tree_right[walk_node] : tree_left[walk_node];
          res.symbol = 8'd0;
          if (!child[15]) begin
            if (int'(child) >= node_total) begin
              stream_error = 1'b1;
              stopped      = 1'b1;
              res.kind     = htbd_pkg::KIND_ERROR;
              found.push_back(res);
            end else begin
              walk_node = int'(child);
            end
          end else begin
            sym       = -(int'(child) + 1);
            walk_node = 0;
            stopped   = 1'b1;
            if (sym > int'(htbd_pkg::END_SYMBOL)) begin
              stream_error = 1'b1;
              res.kind     = htbd_pkg::KIND_ERROR;
            end else if (sym == int'(htbd_pkg::END_SYMBOL)) begin
              stream_done = 1'b1;
              res.kind    = htbd_pkg::KIND_END;
            end else begin
              stopped    = 1'b0;
              res.kind   = htbd_pkg::KIND_DATA;
              res.symbol = sym[7:0];
            end
            found.push_back(res);
          end
        end
      end
      default: effective = 1'b0;
    endcase
    if (found.size() != 0) found[found.size()-1].last = 1'b1;
    for (i = 0; i < found.size(); i++) expected_symbols.push_back(found[i]);
    return effective;
  endfunction

  // True when every node below the loaded count holds a written entry
  function automatic bit tree_loaded();
    int i;
    for (i = 0; i < node_total; i++) begin
      if (!tree_written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic signed [15:0] leaf_code(int sym);
    return 16'(-(sym + 1));
  endfunction

  function automatic htbd_pkg::in_item_t random_item(logic [1:0] op);
    htbd_pkg::in_item_t item;
    item.op          = op;
    item.node_count  = 16'($urandom);
    item.node_index  = 8'($urandom);
    item.left_child  = 16'($urandom);
    item.right_child = 16'($urandom);
    item.data_byte   = 8'($urandom);
    return item;
  endfunction

  // Offer one transaction, hold it until accepted, then predict its results
  task automatic send_item(htbd_pkg::in_item_t item);
    if (tx_gaps && !idle_off) begin
      if (tx_calm_left != 0) begin
        tx_calm_left--;
      end else begin
        case ($urandom_range(0, 7))
          0: begin
            in_valid_i <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk_i);
          end
          1: tx_calm_left = $urandom_range(8, 40);
          default: ;
        endcase
      end
    end
    in_valid_i <= 1'b1;
    in_i       <= item;
    do @(posedge clk_i); while (!in_ready_o);
    void'(decode_item(item));
    items_done++;
  endtask

  task automatic send_header(int count);
    htbd_pkg::in_item_t item;
    item = random_item(htbd_pkg::OP_HEADER);
    item.node_count = 16'(count);
    send_item(item);
  endtask

  task automatic send_entry(int idx, logic signed [15:0] left, logic signed [15:0] right);
    htbd_pkg::in_item_t item;
    item = random_item(htbd_pkg::OP_ENTRY);
    item.node_index  = 8'(idx);
    item.left_child  = left;
    item.right_child = right;
    send_item(item);
  endtask

  task automatic send_byte(logic [7:0] value);
    htbd_pkg::in_item_t item;
    item = random_item(htbd_pkg::OP_BYTE);
    item.data_byte = value;
    send_item(item);
  endtask

  task automatic send_bytes(int count);
    repeat (count) send_byte(8'($urandom));
  endtask

  // Drop a code into a free leaf slot of one of the first span nodes
  task automatic place_leaf(int span, logic signed [15:0] code);
    int i;
    i = $urandom_range(0, span - 1);
    while (!plan_left[i][15] && !plan_right[i][15]) i = (i + 1) % span;
    if (plan_left[i][15] && (!plan_right[i][15] || $urandom_range(0, 1)))
      plan_left[i] = code;
    else
      plan_right[i] = code;
  endtask

  // Build a random tree rooted at node 0 and load it, header first
  task automatic load_tree(int nodes, bit with_end, bit with_fault);
    int i;
    int k;
    int first;
    send_header(nodes);
    if (nodes == 0) return;
    for (i = 0; i < nodes; i++) begin
      plan_left[i]  = -16'sd1;
      plan_right[i] = -16'sd1;
    end
    // Hang each node below an earlier one so the walk never loops
    for (i = 1; i < nodes; i++) place_leaf(i, 16'(i));
    for (i = 0; i < nodes; i++) begin
      if (plan_left[i][15])  plan_left[i]  = leaf_code($urandom_range(0, 255));
      if (plan_right[i][15]) plan_right[i] = leaf_code($urandom_range(0, 255));
    end
    if (with_end) place_leaf(nodes, htbd_pkg::END_LEAF);
    if (with_fault) begin
      if ($urandom_range(0, 1))
        place_leaf(nodes, leaf_code($urandom_range(257, 32767)));
      else
        place_leaf(nodes, 16'($urandom_range(nodes, 32767)));
    end
    first = $urandom_range(0, nodes - 1);
    for (k = 0; k < nodes; k++) begin
      i = (first + k) % nodes;
      send_entry(i, plan_left[i], plan_right[i]);
    end
  endtask

  // Extremes, every op, end and error paths, walk carried across bytes
  task automatic directed_cases_test();
    send_header(0);
    send_byte(8'hA5);
    send_byte(8'h3C);
    send_header(65535);
    send_byte(8'h00);
    send_header(256);
    send_header(3);
    send_entry(0, leaf_code(0), 16'sd1);
    send_entry(1, leaf_code(255), 16'sd2);
    send_entry(2, htbd_pkg::END_LEAF, 16'sh8000);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h02);
    send_byte(8'h03);
    send_header(3);
    send_entry(0, leaf_code(0), 16'sd1);
    send_byte(8'h07);
    send_header(2);
    send_entry(0, leaf_code(0), 16'sh7FFF);
    send_byte(8'h02);
    send_entry(255, 16'sh7FFF, 16'sh8000);
    send_item(random_item(OP_UNUSED));
  endtask

  // Hold the output off while bytes keep coming, so the input stalls
  task automatic backpressure_test();
    load_tree(1, 1'b0, 1'b0);
    tx_gaps = 1'b0;
    hold_req <= hold_req + 1;
    send_bytes(12);
    tx_gaps = 1'b1;
  endtask

  task automatic large_tree_test();
    load_tree(htbd_pkg::MAX_NODES - 1, 1'b0, 1'b0);
    send_bytes(40);
  endtask

  // Mostly well-formed streams, with stray and broken transactions mixed in
  task automatic random_stream_test();
    htbd_pkg::in_item_t item;
    int                 start;
    int                 nodes;
    start = items_done;
    while (items_done - start < RANDOM_ITEMS) begin
      if (items_done - start >= RANDOM_ITEMS - 30) idle_off <= 1'b1;
      if ($urandom_range(0, 7) == 0) begin
        item = random_item(2'($urandom_range(0, 3)));
        if (item.op == htbd_pkg::OP_HEADER && $urandom_range(0, 1))
          item.node_count = 16'($urandom_range(0, 300));
        if (item.op == htbd_pkg::OP_BYTE && !tree_loaded()) item.op = htbd_pkg::OP_ENTRY;
        send_item(item);
      end else begin
        nodes = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 8);
        load_tree(nodes, 1'($urandom_range(0, 1)), ($urandom_range(0, 5) == 0));
        send_bytes($urandom_range(2, 10));
      end
    end
  endtask

  // Receiver: random stall bursts, calm stretches, and one long hold on request
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (idle_off || rx_calm_left != 0) begin
      if (rx_calm_left != 0) rx_calm_left <= rx_calm_left - 1;
      out_ready_i <= 1'b1;
    end else if (rx_stall_left != 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_ready_i   <= 1'b0;
    end else begin
      case ($urandom_range(0, 15))
        0: begin
          rx_stall_left <= $urandom_range(0, 15);
          out_ready_i   <= 1'b0;
        end
        1: begin
          rx_calm_left <= $urandom_range(20, 120);
          out_ready_i  <= 1'b1;
        end
        default: out_ready_i <= 1'b1;
      endcase
    end
  end

  // Compare each accepted result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_symbols.size() == 0) begin
        $display("%0t: unexpected result symbol %0d kind %0d last %0d",
                 $time, out_o.symbol, out_o.kind, out_o.last);
        fail_count++;
      end else begin
        got_symbol = expected_symbols.pop_front();
        if (out_o.symbol != got_symbol.symbol) begin
          $display("%0t: symbol expected %0d, got %0d", $time, got_symbol.symbol, out_o.symbol);
          fail_count++;
        end
        if (out_o.kind != got_symbol.kind) begin
          $display("%0t: kind expected %0d, got %0d", $time, got_symbol.kind, out_o.kind);
          fail_count++;
        end
        if (out_o.last != got_symbol.last) begin
          $display("%0t: last expected %0d, got %0d", $time, got_symbol.last, out_o.last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sequence the tests
  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_i        <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_cases_test();
    backpressure_test();
    large_tree_test();
    random_stream_test();
    in_valid_i <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
